[hw/rtl/glcd_pkg.sv]
// Package: shared types and constants for the panel pixel plotter.
`timescale 1ns / 1ps
package glcd_pkg;

    localparam int COLUMNS_PER_HALF_DEF = 64;
    localparam int PAGES_DEF            = 8;

    localparam logic [7:0] CMD_COLUMN = 8'h40;
    localparam logic [7:0] COL_MASK   = 8'h7F;
    localparam logic [7:0] CMD_PAGE   = 8'hB8;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
    } glcd_pixel_t;

    typedef struct packed {
        logic       half;
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } glcd_write_t;

endpackage

[hw/rtl/glcd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module glcd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/glcd_pixel_plot_shadow_buffer_top.sv]
// Top level: pixel plotter keeping a shadow copy of a two-half graphic panel.
`timescale 1ns / 1ps
//
// Usage:
//   Input: drive pixel (x, y, color) and raise start; the word is taken at a
//   rising edge where start is high and busy is low.
//   Output: each panel bus word appears on result for one cycle with strobe
//   high; the receiver cannot stall, so it must take every strobed word.
//   An in-range pixel gives three words, in states S_COL, S_PAGE and S_DATA
//   after it is taken: column command, page command, then the data byte
//   with last set. A pixel off the panel gives no words and busy stays low.
//   Busy is low during the data word, so the next pixel may be taken while
//   that word is out. The pace is set by the three bus words and the single
//   read-modify-write of the shadow RAM (read issued at accept, written back
//   in S_COL).
//   Reset: the shadow RAM is swept to zero one entry per cycle after reset;
//   the sweep covers 2 << (PAGE_W + COL_W) entries, PAGE_W being
//   clog2(PAGES) but at least 1 and COL_W clog2(COLUMNS_PER_HALF) (1024
//   with the defaults), with busy high throughout.
//
module glcd_pixel_plot_shadow_buffer_top
    import glcd_pkg::*;
#(
    parameter int COLUMNS_PER_HALF = COLUMNS_PER_HALF_DEF,
    parameter int PAGES            = PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  glcd_pixel_t pixel,
    output logic        strobe,
    output glcd_write_t result
);

    localparam int COL_W  = $clog2(COLUMNS_PER_HALF);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ADDR_W = 1 + PAGE_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [8:0] PANEL_W_C = 9'(2 * COLUMNS_PER_HALF);
    localparam logic [8:0] PANEL_H_C = 9'(8 * PAGES);
    localparam logic [8:0] CPH_C     = 9'(COLUMNS_PER_HALF);
    localparam logic [7:0] CPH8_C    = 8'(COLUMNS_PER_HALF);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_COL   = 5'b00100,
        S_PAGE  = 5'b01000,
        S_DATA  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              half_reg;
    logic [COL_W-1:0]  col_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [2:0]        bit_reg;
    logic              color_reg;
    logic [7:0]        byte_reg;

    logic              accept;
    logic              in_range;
    logic              half_in;
    logic [7:0]        col8_in;
    logic [COL_W-1:0]  col_in;
    logic [PAGE_W-1:0] page_in;
    logic [ADDR_W-1:0] raddr;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [7:0]        rdata;
    logic [7:0]        bit_mask;
    logic [7:0]        new_byte;

    assign busy   = (state_reg == S_CLEAR) || (state_reg == S_COL) || (state_reg == S_PAGE);
    assign accept = start && !busy;

    assign in_range = ({1'b0, pixel.x} < PANEL_W_C) && ({1'b0, pixel.y} < PANEL_H_C);
    assign half_in  = ({1'b0, pixel.x} >= CPH_C);
    assign col8_in  = pixel.x - (half_in ? CPH8_C : 8'd0);
    assign col_in   = col8_in[COL_W-1:0];
    assign page_in  = pixel.y[PAGE_W+2:3];
    assign raddr    = {half_in, page_in, col_in};

    assign bit_mask = 8'd1 << bit_reg;
    assign new_byte = color_reg ? (rdata | bit_mask) : (rdata & ~bit_mask);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        we         = 1'b0;
        waddr      = {half_reg, page_reg, col_reg};
        wdata      = new_byte;
        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = 8'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && in_range)
                begin
                    state_next = S_COL;
                end
            end
            S_COL:
            begin
                we         = 1'b1;
                state_next = S_PAGE;
            end
            S_PAGE:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                state_next = (start && in_range) ? S_COL : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            half_reg  <= half_in;
            col_reg   <= col_in;
            page_reg  <= page_in;
            bit_reg   <= pixel.y[2:0];
            color_reg <= pixel.color;
        end
        if (state_reg == S_COL)
        begin
            byte_reg <= new_byte;
        end
    end

    glcd_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_shadow (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign strobe = (state_reg == S_COL) || (state_reg == S_PAGE) || (state_reg == S_DATA);

    always_comb
    begin
        result.half    = half_reg;
        result.is_data = 1'b0;
        result.last    = 1'b0;
        result.bus_byte = (8'(col_reg) | CMD_COLUMN) & COL_MASK;
        case (state_reg)
            S_PAGE:
            begin
                result.bus_byte = 8'(page_reg) | CMD_PAGE;
            end
            S_DATA:
            begin
                result.is_data  = 1'b1;
                result.last     = 1'b1;
                result.bus_byte = byte_reg;
            end
            default:
            begin
                result.bus_byte = (8'(col_reg) | CMD_COLUMN) & COL_MASK;
            end
        endcase
    end

    a_accept_starts_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range) |=> (state_reg == S_COL))
        else $error("in-range pixel did not start a write sequence");

    a_col_then_page: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COL) |=> (state_reg == S_PAGE))
        else $error("column command not followed by page command");

    a_page_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAGE) |=> (strobe && result.last && result.is_data))
        else $error("page command not followed by data word");

    a_no_write_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!strobe && busy))
        else $error("output or accept during clearing pass");

endmodule
